[hdl/page_framebuffer_engine_top_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef PAGE_FRAMEBUFFER_ENGINE_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, muted while rst_n is low
`define PFE_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// next-cycle implication, sampled on clk, muted while rst_n is low
`define PFE_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

[hdl/pfe_pkg.sv]
// Shared types and constants of the page frame buffer engine.
package pfe_pkg;

  localparam int CMD_W     = 2;
  localparam int X_W       = 8;
  localparam int Y_W       = 7;
  localparam int PAGE_W    = 3;
  localparam int KIND_W    = 2;
  localparam int PAYLOAD_W = 64;
  localparam int IN_DATA_W = 24;

  localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD    = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD   = 8'h10;
  localparam logic [7:0] ALL_ON         = 8'hFF;

  typedef enum logic [1:0] {
    CMD_DRAW    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_FILL    = 2'd2,
    CMD_REFRESH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_WR,
    ST_READ_OUT,
    ST_FILL,
    ST_CTRL_OUT,
    ST_GATHER,
    ST_GATHER_END,
    ST_DATA_OUT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_PIXEL_IN,
    ADDR_PIXEL,
    ADDR_SWEEP,
    ADDR_COL
  } addr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic      latch;
    logic      mem_re;
    logic      mem_we;
    addr_sel_t addr_sel;
    logic      wr_ones;
    logic      sweep_inc;
    logic      col_inc;
    logic      word_inc;
    logic      out_load;
    kind_t     out_sel;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_last;
    logic on_screen;
    logic page_ok;
    logic byte_last;
    logic word_last;
    logic out_free;
  } sts_t;

endpackage

[hdl/pfe_ram.sv]
// Generic single-port RAM with registered read data.
module pfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/pfe_ctrl.sv]
// Command sequencer of the page frame buffer engine.
module pfe_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic [pfe_pkg::CMD_W-1:0]      in_cmd,
  output logic                           in_tready,
  input  pfe_pkg::sts_t                  sts,
  output pfe_pkg::ctl_t                  ctl
);

  pfe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfe_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfe_pkg::ST_CLEAR: begin
        if (sts.sweep_last) state_nxt = pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (pfe_pkg::cmd_t'(in_cmd))
            pfe_pkg::CMD_DRAW:    state_nxt = pfe_pkg::ST_DRAW_WR;
            pfe_pkg::CMD_READ:    state_nxt = pfe_pkg::ST_READ_OUT;
            pfe_pkg::CMD_FILL:    state_nxt = pfe_pkg::ST_FILL;
            pfe_pkg::CMD_REFRESH: state_nxt = pfe_pkg::ST_CTRL_OUT;
            default:              state_nxt = pfe_pkg::ST_IDLE;
          endcase
        end
      end
      pfe_pkg::ST_DRAW_WR: state_nxt = pfe_pkg::ST_IDLE;
      pfe_pkg::ST_READ_OUT: begin
        if (sts.out_free) state_nxt = pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_FILL: begin
        if (sts.sweep_last) state_nxt = pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_CTRL_OUT: begin
        if (!sts.page_ok) state_nxt = pfe_pkg::ST_IDLE;
        else if (sts.out_free) state_nxt = pfe_pkg::ST_GATHER;
      end
      pfe_pkg::ST_GATHER: begin
        if (sts.byte_last) state_nxt = pfe_pkg::ST_GATHER_END;
      end
      pfe_pkg::ST_GATHER_END: state_nxt = pfe_pkg::ST_DATA_OUT;
      pfe_pkg::ST_DATA_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.word_last ? pfe_pkg::ST_IDLE : pfe_pkg::ST_GATHER;
        end
      end
      default: state_nxt = pfe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    ctl           = '0;
    ctl.addr_sel  = pfe_pkg::ADDR_PIXEL_IN;
    ctl.out_sel   = pfe_pkg::KIND_PIXEL;
    case (state_r)
      pfe_pkg::ST_CLEAR, pfe_pkg::ST_FILL: begin
        ctl.mem_we    = 1'b1;
        ctl.wr_ones   = 1'b1;
        ctl.addr_sel  = pfe_pkg::ADDR_SWEEP;
        ctl.sweep_inc = 1'b1;
      end
      pfe_pkg::ST_IDLE: begin
        // pixel read goes out in the accept cycle
        in_tready  = 1'b1;
        ctl.latch  = in_tvalid;
        ctl.mem_re = in_tvalid;
      end
      pfe_pkg::ST_DRAW_WR: begin
        ctl.mem_we   = sts.on_screen;
        ctl.addr_sel = pfe_pkg::ADDR_PIXEL;
      end
      pfe_pkg::ST_READ_OUT: begin
        ctl.out_load = sts.out_free;
        ctl.out_sel  = pfe_pkg::KIND_PIXEL;
      end
      pfe_pkg::ST_CTRL_OUT: begin
        ctl.out_load = sts.page_ok && sts.out_free;
        ctl.out_sel  = pfe_pkg::KIND_CTRL;
      end
      pfe_pkg::ST_GATHER: begin
        ctl.mem_re   = 1'b1;
        ctl.addr_sel = pfe_pkg::ADDR_COL;
        ctl.col_inc  = 1'b1;
      end
      pfe_pkg::ST_GATHER_END: begin
        ctl.addr_sel = pfe_pkg::ADDR_COL;
      end
      pfe_pkg::ST_DATA_OUT: begin
        ctl.out_load = sts.out_free;
        ctl.word_inc = sts.out_free;
        ctl.out_sel  = pfe_pkg::KIND_DATA;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

[hdl/pfe_datapath.sv]
// Frame store, address generation, word gather and output register.
module pfe_datapath #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [pfe_pkg::X_W-1:0]           in_x_pos,
  input  logic [pfe_pkg::Y_W-1:0]           in_y_pos,
  input  logic                              in_pixel_on,
  input  logic [pfe_pkg::PAGE_W-1:0]        in_page_sel,
  input  pfe_pkg::ctl_t                     ctl,
  output pfe_pkg::sts_t                     sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pfe_pkg::PAYLOAD_W-1:0]     out_tdata,
  output logic [pfe_pkg::KIND_W-1:0]        out_tuser,
  output logic                              out_tlast
);

  localparam int DEPTH      = COLUMNS * PAGES;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_WORDS = (COLUMNS + 7) / 8;
  localparam int WW         = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  logic [pfe_pkg::X_W-1:0]    x_r;
  logic [pfe_pkg::Y_W-1:0]    y_r;
  logic                       on_r;
  logic [pfe_pkg::PAGE_W-1:0] page_r;
  logic [AW-1:0]              sweep_r;
  logic [2:0]                 b_r;
  logic [WW-1:0]              w_r;
  logic                       cap_r;
  logic                       col_ok_r;
  logic [pfe_pkg::PAYLOAD_W-1:0] gather_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [pfe_pkg::PAYLOAD_W-1:0] out_data_r, out_data_nxt;
  pfe_pkg::kind_t             out_kind_r;
  logic                       out_last_r, out_last_nxt;

  logic [31:0]   pix_in_full, pix_full, col_full;
  logic [WW+2:0] col;
  logic          col_ok;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata, bit_mask;
  logic          pix_bit;

  always_comb begin
    pix_in_full = 32'(in_y_pos[pfe_pkg::Y_W-1:3]) * 32'(COLUMNS) + 32'(in_x_pos);
    pix_full    = 32'(y_r[pfe_pkg::Y_W-1:3]) * 32'(COLUMNS) + 32'(x_r);
    col         = {w_r, b_r};
    col_full    = 32'(page_r) * 32'(COLUMNS) + 32'(col);
    col_ok      = 32'(col) < 32'(COLUMNS);
  end

  always_comb begin
    case (ctl.addr_sel)
      pfe_pkg::ADDR_PIXEL_IN: mem_addr = pix_in_full[AW-1:0];
      pfe_pkg::ADDR_PIXEL:    mem_addr = pix_full[AW-1:0];
      pfe_pkg::ADDR_SWEEP:    mem_addr = sweep_r;
      pfe_pkg::ADDR_COL:      mem_addr = col_full[AW-1:0];
      default:                mem_addr = sweep_r;
    endcase
  end

  assign bit_mask = 8'(1) << y_r[2:0];

  always_comb begin
    if (ctl.wr_ones) mem_wdata = pfe_pkg::ALL_ON;
    else if (on_r)   mem_wdata = mem_rdata | bit_mask;
    else             mem_wdata = mem_rdata & ~bit_mask;
  end

  pfe_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.mem_we),
    .re    (ctl.mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    sts.sweep_last = sweep_r == AW'(DEPTH - 1);
    sts.on_screen  = (32'(x_r) < 32'(COLUMNS)) && (32'(y_r) < 32'(PAGES * 8));
    sts.page_ok    = 32'(page_r) < 32'(PAGES);
    sts.byte_last  = b_r == 3'd7;
    sts.word_last  = w_r == WW'(DATA_WORDS - 1);
    sts.out_free   = !out_valid_r || out_tready;
  end

  // input fields and store data words carry no reset
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      x_r    <= in_x_pos;
      y_r    <= in_y_pos;
      on_r   <= in_pixel_on;
      page_r <= in_page_sel;
    end
    col_ok_r <= col_ok;
    if (cap_r) begin
      // bytes enter at the top, so column 0 ends in the low byte
      gather_r <= {(col_ok_r ? mem_rdata : 8'h00), gather_r[pfe_pkg::PAYLOAD_W-1:8]};
    end
    out_data_r <= out_data_nxt;
    out_kind_r <= ctl.out_load ? ctl.out_sel : out_kind_r;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      b_r         <= '0;
      w_r         <= '0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.latch) begin
        sweep_r <= '0;
        b_r     <= '0;
        w_r     <= '0;
      end else begin
        if (ctl.sweep_inc) sweep_r <= sweep_r + AW'(1);
        if (ctl.col_inc)   b_r     <= b_r + 3'd1;
        if (ctl.word_inc)  w_r     <= w_r + WW'(1);
      end
      cap_r       <= ctl.mem_re && (ctl.addr_sel == pfe_pkg::ADDR_COL);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign pix_bit = sts.on_screen && mem_rdata[y_r[2:0]];

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
      case (ctl.out_sel)
        pfe_pkg::KIND_PIXEL: begin
          out_data_nxt = pfe_pkg::PAYLOAD_W'(pix_bit);
          out_last_nxt = 1'b1;
        end
        pfe_pkg::KIND_CTRL: begin
          out_data_nxt = pfe_pkg::PAYLOAD_W'({pfe_pkg::COL_HIGH_CMD, pfe_pkg::COL_LOW_CMD,
                                              pfe_pkg::PAGE_ADDR_BASE + 8'(page_r)});
          out_last_nxt = 1'b0;
        end
        pfe_pkg::KIND_DATA: begin
          out_data_nxt = gather_r;
          out_last_nxt = sts.word_last;
        end
        default: begin
          out_data_nxt = '0;
          out_last_nxt = 1'b0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/page_framebuffer_engine_top.sv]
// Top level of the page frame buffer engine.
// Keeps a COLUMNS x (PAGES*8) monochrome frame, one byte per page and column,
// bit (y mod 8) of a byte being row y.
// in_* stream: one word per command (draw, read, fill, refresh page).
// out_* stream: results; tuser gives the kind, tlast marks a command's final word.
// Draw: no result. Read: one pixel word.
// Fill: writes all COLUMNS*PAGES store bytes to all ones, one store byte written per cycle.
// Refresh: one command word, then ceil(COLUMNS/8) data words (no words at all for a
// page of PAGES or more); each data word gathers 8 byte reads on the single store
// port, waits for the registered read data, then is handed to the output register.
// Commands run one at a time; a new one is taken while the last result
// still sits in the output register.
// After reset the store is swept to all ones, all COLUMNS*PAGES bytes (1024 at the
// default size), with in_tready low.
// A stalled receiver holds the output word and the command waiting to emit
// its next word; draw and fill go on regardless.
module page_framebuffer_engine_top #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command[1:0], x_pos[9:2], y_pos[16:10], pixel_on[17], page_sel[20:18], zero[23:21]
  input  logic [pfe_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // payload[63:0]
  output logic [pfe_pkg::PAYLOAD_W-1:0]     out_tdata,
  // kind[1:0]
  output logic [pfe_pkg::KIND_W-1:0]        out_tuser,
  output logic                              out_tlast
);

  pfe_pkg::ctl_t ctl;
  pfe_pkg::sts_t sts;

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tdata[1:0]),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  pfe_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_x_pos    (in_tdata[9:2]),
    .in_y_pos    (in_tdata[16:10]),
    .in_pixel_on (in_tdata[17]),
    .in_page_sel (in_tdata[20:18]),
    .ctl         (ctl),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

[hdl/pfe_checker.sv]
// Port-level checks of the page frame buffer engine, bound to the top level.
`include "page_framebuffer_engine_top_macros.svh"

module pfe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [pfe_pkg::PAYLOAD_W-1:0] out_tdata,
  input logic [pfe_pkg::KIND_W-1:0]    out_tuser,
  input logic                          out_tlast
);

  `PFE_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output word changed while stalled")
  `PFE_ASSERT_NOW(a_ctrl_not_last, out_tvalid && out_tuser == pfe_pkg::KIND_CTRL, !out_tlast && out_tdata[63:8] == 56'h1000, "bad controller command word")
  `PFE_ASSERT_NOW(a_pixel_word, out_tvalid && out_tuser == pfe_pkg::KIND_PIXEL, out_tlast && out_tdata[63:1] == 63'd0, "bad pixel word")
  `PFE_ASSERT_NEXT(a_ctrl_then_data, out_tvalid && out_tready && out_tuser == pfe_pkg::KIND_CTRL, !in_tready && (!out_tvalid || out_tuser == pfe_pkg::KIND_DATA), "refresh released input before its data")
  `PFE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "second word taken while a command runs")

endmodule

bind page_framebuffer_engine_top pfe_checker u_pfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[tb/page_framebuffer_engine_top_tb.sv]
// Self-checking testbench for the page frame buffer engine: pixel draw/read, fill, page refresh.
module page_framebuffer_engine_top_tb;

  localparam int COLUMNS    = 128;
  localparam int PAGES      = 8;
  localparam int ROWS       = PAGES * 8;
  localparam int DATA_WORDS = (COLUMNS + 7) / 8;
  // longest silent stretch: a fill walks the whole store
  localparam int TAIL_CYCLES = COLUMNS * PAGES + 100;

  typedef struct packed {
    pfe_pkg::kind_t                kind;
    logic [pfe_pkg::PAYLOAD_W-1:0] payload;
    logic                          last;
  } out_word_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [pfe_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [pfe_pkg::PAYLOAD_W-1:0] out_tdata;
  logic [pfe_pkg::KIND_W-1:0]    out_tuser;
  logic                          out_tlast;

  logic [7:0] frame_img [COLUMNS*PAGES];
  out_word_t  owed_words [$];
  int         mismatches = 0;
  bit         in_gaps = 1'b1;
  bit         out_gaps = 1'b1;
  int         long_hold_req = 0;

  page_framebuffer_engine_top #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  // Update the frame image for one accepted command and queue the words it owes.
  task automatic frame_apply(pfe_pkg::cmd_t cmd, logic [7:0] x, logic [6:0] y, logic on,
                             logic [2:0] page);
    int                            idx;
    int                            col;
    bit                            visible;
    logic [pfe_pkg::PAYLOAD_W-1:0] word;
    visible = (int'(x) < COLUMNS) && (int'(y) < ROWS);
    idx = int'(y[6:3]) * COLUMNS + int'(x);
    case (cmd)
      pfe_pkg::CMD_DRAW: begin
        if (visible) frame_img[idx][y[2:0]] = on;
      end
      pfe_pkg::CMD_READ: begin
        word = '0;
        if (visible) word[0] = frame_img[idx][y[2:0]];
        owed_words.push_back(out_word_t'{kind: pfe_pkg::KIND_PIXEL, payload: word,
                                         last: 1'b1});
      end
      pfe_pkg::CMD_FILL: begin
        foreach (frame_img[i]) frame_img[i] = pfe_pkg::ALL_ON;
      end
      default: begin
        if (int'(page) < PAGES) begin
          word = '0;
          word[23:0] = {pfe_pkg::COL_HIGH_CMD, pfe_pkg::COL_LOW_CMD,
                        pfe_pkg::PAGE_ADDR_BASE + 8'(page)};
          owed_words.push_back(out_word_t'{kind: pfe_pkg::KIND_CTRL, payload: word,
                                           last: 1'b0});
          for (int w = 0; w < DATA_WORDS; w++) begin
            word = '0;
            for (int b = 0; b < 8; b++) begin
              col = w * 8 + b;
              if (col < COLUMNS) word[b*8 +: 8] = frame_img[int'(page) * COLUMNS + col];
            end
            owed_words.push_back(out_word_t'{kind: pfe_pkg::KIND_DATA, payload: word,
                                             last: (w == DATA_WORDS - 1)});
          end
        end
      end
    endcase
  endtask

  // Offer one command word; returns at the edge where it is taken.
  task automatic send_cmd(pfe_pkg::cmd_t cmd, logic [7:0] x, logic [6:0] y, logic on,
                          logic [2:0] page);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, page, on, y, x, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frame_apply(cmd, x, y, on, page);
  endtask

  // Receiver: random stall bursts, plus long holds on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0) begin
        if (long_hold_req > 0) begin
          hold_left = long_hold_req;
          long_hold_req = 0;
        end else if (out_gaps && $urandom_range(0, 5) == 0) begin
          hold_left = $urandom_range(1, 12);
        end
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: expected none, actual kind %0d payload %h last %b",
                 $time, out_tuser, out_tdata, out_tlast);
      end else begin
        want = owed_words.pop_front();
        if (out_tuser !== want.kind) begin
          mismatches++;
          $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, out_tuser);
        end
        if (out_tdata !== want.payload) begin
          mismatches++;
          $display("%0t: payload mismatch: expected %h actual %h",
                   $time, want.payload, out_tdata);
        end
        if (out_tlast !== want.last) begin
          mismatches++;
          $display("%0t: last mismatch: expected %b actual %b", $time, want.last, out_tlast);
        end
      end
    end
  end

  task automatic test_reset_image();
    send_cmd(pfe_pkg::CMD_READ, 8'd0, 7'd0, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'(COLUMNS - 1), 7'(ROWS - 1), 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_REFRESH, 8'd0, 7'd0, 1'b0, 3'd0);
  endtask

  task automatic test_draw_read();
    send_cmd(pfe_pkg::CMD_DRAW, 8'd0, 7'd0, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_DRAW, 8'(COLUMNS - 1), 7'(ROWS - 1), 1'b0, 3'd7);
    send_cmd(pfe_pkg::CMD_DRAW, 8'd5, 7'd13, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'd0, 7'd0, 1'b1, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'(COLUMNS - 1), 7'(ROWS - 1), 1'b1, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'd5, 7'd13, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_DRAW, 8'd5, 7'd13, 1'b1, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'd5, 7'd13, 1'b0, 3'd0);
  endtask

  // coordinates past the screen edge: draws do nothing, reads give 0
  task automatic test_off_screen();
    send_cmd(pfe_pkg::CMD_DRAW, 8'(COLUMNS), 7'd0, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_DRAW, 8'hFF, 7'd3, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_DRAW, 8'd1, 7'(ROWS), 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_DRAW, 8'd2, 7'h7F, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'd200, 7'd10, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'd0, 7'(ROWS), 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'hFF, 7'h7F, 1'b1, 3'd7);
  endtask

  task automatic test_refresh();
    send_cmd(pfe_pkg::CMD_REFRESH, 8'hFF, 7'h7F, 1'b1, 3'd7);
    send_cmd(pfe_pkg::CMD_REFRESH, 8'd0, 7'd0, 1'b0, 3'd1);
  endtask

  task automatic test_fill();
    send_cmd(pfe_pkg::CMD_FILL, 8'd0, 7'd0, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'd0, 7'd0, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_REFRESH, 8'd0, 7'd0, 1'b0, 3'd0);
  endtask

  // hold the receiver off long enough that the engine backs up into the input
  task automatic test_backpressure();
    in_gaps = 1'b0;
    long_hold_req = 400;
    send_cmd(pfe_pkg::CMD_REFRESH, 8'd0, 7'd0, 1'b0, 3'd2);
    send_cmd(pfe_pkg::CMD_READ, 8'd0, 7'd0, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_REFRESH, 8'd0, 7'd0, 1'b0, 3'd7);
    send_cmd(pfe_pkg::CMD_READ, 8'd5, 7'd13, 1'b0, 3'd0);
    send_cmd(pfe_pkg::CMD_READ, 8'd6, 7'd13, 1'b0, 3'd0);
    in_gaps = 1'b1;
  endtask

  task automatic test_random(int count);
    int            pick;
    pfe_pkg::cmd_t cmd;
    logic [7:0]    x;
    logic [6:0]    y;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = pfe_pkg::CMD_DRAW;
      else if (pick < 78) cmd = pfe_pkg::CMD_READ;
      else if (pick < 96) cmd = pfe_pkg::CMD_REFRESH;
      else                cmd = pfe_pkg::CMD_FILL;
      pick = $urandom_range(0, 9);
      // half the time a small corner so reads land on drawn pixels
      if (pick < 5) begin
        x = 8'($urandom_range(0, 15));
        y = 7'($urandom_range(0, 15));
      end else if (pick < 9) begin
        x = 8'($urandom_range(0, COLUMNS - 1));
        y = 7'($urandom_range(0, ROWS - 1));
      end else begin
        x = 8'($urandom_range(0, 255));
        y = 7'($urandom_range(0, 127));
      end
      send_cmd(cmd, x, y, ($urandom_range(0, 9) < 3), 3'($urandom_range(0, 7)));
    end
  endtask

  task automatic finish_run();
    in_tvalid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  endtask

  initial begin
    foreach (frame_img[i]) frame_img[i] = pfe_pkg::ALL_ON;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_image();
    test_draw_read();
    test_off_screen();
    test_refresh();
    test_fill();
    test_backpressure();
    test_random(200);
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    test_random(40);
    finish_run();
  end

  initial begin
    #(12 * 900000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[page_framebuffer_engine_top.f]
+incdir+hdl
hdl/pfe_pkg.sv
hdl/pfe_ram.sv
hdl/pfe_ctrl.sv
hdl/pfe_datapath.sv
hdl/page_framebuffer_engine_top.sv
hdl/pfe_checker.sv
tb/page_framebuffer_engine_top_tb.sv
